>>> rtl/core/i2c_write_read_sequencer_top_defines.svh
// Assertion macros for the I2C write/read sequencer.
// Used by the port checker; needs no other file.
`ifndef I2C_WRITE_READ_SEQUENCER_TOP_DEFINES_SVH
`define I2C_WRITE_READ_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define I2CWS_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("i2cws check failed");

// Next-cycle implication, disabled while in reset.
`define I2CWS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("i2cws check failed");

`endif

>>> rtl/core/i2cws_pkg.sv
// Shared types and codes for the I2C write/read sequencer.
// No dependencies.
package i2cws_pkg;

  localparam int unsigned MAX_BYTES_DEF = 16;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_POLL  = 2'd2;

  localparam logic [3:0] CMD_NONE        = 4'd0;
  localparam logic [3:0] CMD_SINGLE_SEND = 4'd1;
  localparam logic [3:0] CMD_SEND_START  = 4'd2;
  localparam logic [3:0] CMD_SEND_CONT   = 4'd3;
  localparam logic [3:0] CMD_SEND_FINISH = 4'd4;
  localparam logic [3:0] CMD_SINGLE_RECV = 4'd5;
  localparam logic [3:0] CMD_RECV_START  = 4'd6;
  localparam logic [3:0] CMD_RECV_CONT   = 4'd7;
  localparam logic [3:0] CMD_RECV_FINISH = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SEND   = 4'b0010,
    PH_RSTART = 4'b0100,
    PH_RECV   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] load_slot;
    logic [7:0] load_value;
    logic [6:0] target_address;
    logic [4:0] write_count;
    logic [4:0] read_count;
    logic       ctrl_busy;
    logic [3:0] err_status;
    logic [7:0] received_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] command;
    logic [6:0] bus_address;
    logic       read_flag;
    logic [7:0] send_value;
    logic       recv_valid;
    logic [3:0] recv_slot;
    logic [7:0] recv_value;
    logic       done_res;
    logic [3:0] fault_bits;
    logic       rejected;
  } out_item_t;

endpackage

>>> rtl/core/i2cws_if.sv
// Valid/ready channels of the I2C write/read sequencer.
// Depends on i2cws_pkg.
interface i2cws_in_if;
  import i2cws_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cws_out_if;
  import i2cws_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/i2cws_txbuf.sv
// Transmit byte buffer: one write port, one prefetched read port.
// Write-first forwarding onto the registered read word. No dependencies.
module i2cws_txbuf #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/i2c_write_read_sequencer_top.sv
// Latency: a result word is registered at the edge that accepts its input word.
// Throughput: one word per cycle; in_ch.ready drops only while a result is stalled.
// The next transmit byte is prefetched from the buffer into its registered read word.
// Reset (synchronous, rst_n low): idle phase, counters and address cleared,
// output register empty. The transmit buffer is not cleared.
module i2c_write_read_sequencer_top #(
  parameter int unsigned MAX_BYTES = i2cws_pkg::MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  i2cws_in_if.sink    in_ch,
  i2cws_out_if.source out_ch
);
  import i2cws_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BYTES);
  localparam int unsigned CW = $clog2(MAX_BYTES + 1);

  phase_t        phase_r, phase_nxt;
  logic [6:0]    addr_r, addr_nxt;
  logic [CW-1:0] wt_r, wt_nxt;
  logic [CW-1:0] rt_r, rt_nxt;
  logic [CW-1:0] wsf_r, wsf_nxt;
  logic [CW-1:0] rsf_r, rsf_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, res;

  logic          accept;
  in_item_t      item;
  logic [CW-1:0] wc_c, rc_c, rem;
  logic          buf_we;
  logic [AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_rdata;

  assign item         = in_ch.data;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign wc_c = (32'(item.write_count) > 32'(MAX_BYTES)) ? CW'(MAX_BYTES)
                                                        : CW'(item.write_count);
  assign rc_c = (32'(item.read_count) > 32'(MAX_BYTES)) ? CW'(MAX_BYTES)
                                                       : CW'(item.read_count);

  assign buf_we    = accept && (item.action == ACT_LOAD) &&
                     (32'(item.load_slot) < 32'(MAX_BYTES));
  assign buf_waddr = AW'(item.load_slot);
  assign buf_raddr = (phase_nxt == PH_IDLE) ? '0 : wsf_nxt[AW-1:0];

  i2cws_txbuf #(
    .DEPTH (MAX_BYTES)
  ) u_txbuf (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (buf_waddr),
    .wr_data (item.load_value),
    .rd_addr (buf_raddr),
    .rd_data (buf_rdata)
  );

  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    wt_nxt    = wt_r;
    rt_nxt    = rt_r;
    wsf_nxt   = wsf_r;
    rsf_nxt   = rsf_r;
    res       = '0;
    rem       = '0;
    if (accept) begin
      unique case (item.action)
        ACT_LOAD: begin
        end
        ACT_START: begin
          if ((phase_r != PH_IDLE) || ((wc_c == '0) && (rc_c == '0))) begin
            res.rejected = 1'b1;
          end else begin
            addr_nxt        = item.target_address;
            wt_nxt          = wc_c;
            rt_nxt          = rc_c;
            wsf_nxt         = '0;
            rsf_nxt         = '0;
            res.bus_address = item.target_address;
            if (wc_c == '0) begin
              res.read_flag = 1'b1;
              phase_nxt     = PH_RSTART;
            end else begin
              res.send_value = buf_rdata;
              wsf_nxt        = CW'(1);
              if (wc_c == CW'(1)) begin
                res.command = CMD_SINGLE_SEND;
                phase_nxt   = PH_RSTART;
              end else begin
                res.command = CMD_SEND_START;
                phase_nxt   = PH_SEND;
              end
            end
          end
        end
        ACT_POLL: begin
          if ((phase_r != PH_IDLE) && !item.ctrl_busy) begin
            if (item.err_status != 4'd0) begin
              res.done_res   = 1'b1;
              res.fault_bits = item.err_status;
              phase_nxt      = PH_IDLE;
            end else begin
              unique case (phase_r)
                PH_SEND: begin
                  if (wt_r > wsf_r) begin
                    rem            = wt_r - wsf_r;
                    res.send_value = buf_rdata;
                    wsf_nxt        = wsf_r + CW'(1);
                    if (rem == CW'(1)) begin
                      res.command = CMD_SEND_FINISH;
                      if (rt_r == '0) begin
                        res.done_res = 1'b1;
                        phase_nxt    = PH_IDLE;
                      end else begin
                        phase_nxt = PH_RSTART;
                      end
                    end else begin
                      res.command = CMD_SEND_CONT;
                    end
                  end
                end
                PH_RSTART: begin
                  if (rt_r == '0) begin
                    res.done_res = 1'b1;
                    phase_nxt    = PH_IDLE;
                  end else begin
                    res.command     = (rt_r > CW'(1)) ? CMD_RECV_START : CMD_SINGLE_RECV;
                    res.bus_address = addr_r;
                    res.read_flag   = 1'b1;
                    phase_nxt       = PH_RECV;
                  end
                end
                PH_RECV: begin
                  if (rt_r > rsf_r) begin
                    rem            = rt_r - rsf_r;
                    rsf_nxt        = rsf_r + CW'(1);
                    res.recv_valid = 1'b1;
                    res.recv_slot  = 4'(rt_r - rsf_nxt);
                    res.recv_value = item.received_value;
                    if (rem == CW'(1)) begin
                      res.done_res = 1'b1;
                      phase_nxt    = PH_IDLE;
                    end else begin
                      res.command = (rem == CW'(2)) ? CMD_RECV_FINISH : CMD_RECV_CONT;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      addr_r      <= '0;
      wt_r        <= '0;
      rt_r        <= '0;
      wsf_r       <= '0;
      rsf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      addr_r      <= addr_nxt;
      wt_r        <= wt_nxt;
      rt_r        <= rt_nxt;
      wsf_r       <= wsf_nxt;
      rsf_r       <= rsf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

endmodule

>>> rtl/core/i2cws_checker.sv
// Port-level checks for the I2C write/read sequencer, bound to the top level.
// Depends on i2cws_pkg and i2c_write_read_sequencer_top_defines.svh.
`include "i2c_write_read_sequencer_top_defines.svh"

module i2cws_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cws_pkg::out_item_t out_data
);
  import i2cws_pkg::*;

  `I2CWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `I2CWS_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  `I2CWS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)
  `I2CWS_ASSERT_IMP(a_fault_aborts, clk, rst_n, out_valid && (out_data.fault_bits != 4'd0), out_data.done_res && (out_data.command == CMD_NONE))
  `I2CWS_ASSERT_IMP(a_reject_quiet, clk, rst_n, out_valid && out_data.rejected, (out_data.command == CMD_NONE) && !out_data.done_res && !out_data.recv_valid)

endmodule

bind i2c_write_read_sequencer_top i2cws_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

>>> sim/tb.sv
// Self-checking testbench for i2c_write_read_sequencer_top: valid/ready traffic with random gaps
// on both sides, with every result word checked against an in-bench transaction tracker.
// Depends on i2cws_pkg, i2cws_if and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cws_pkg::*;

  localparam int unsigned DEPTH = MAX_BYTES_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 250000;

  logic clk;
  logic rst_n;

  i2cws_in_if in_ch();
  i2cws_out_if out_ch();

  i2c_write_read_sequencer_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // transaction tracker state
  phase_t     trk_phase;
  logic [6:0] trk_addr;
  logic [4:0] wr_total, rd_total, wr_sent, rd_got;
  logic [7:0] tx_bytes [DEPTH];

  in_item_t  host_requests[$];
  out_item_t words_due[$];
  out_item_t want;

  int  total_items, accepted, checked, errors, cycles;
  int  finished, aborted, refused, recv_bytes;
  int  in_wait, out_wait;
  bit  in_steady, out_steady;
  bit  in_taken, out_taken;

  function automatic int draw_gap(inout bit steady);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [4:0] clamp_count(logic [4:0] c);
    return (c > DEPTH) ? 5'(DEPTH) : c;
  endfunction

  function automatic out_item_t controller_word(in_item_t w);
    out_item_t  r;
    logic [4:0] wc, rc;
    r = '0;
    wc = clamp_count(w.write_count);
    rc = clamp_count(w.read_count);
    case (w.action)
      ACT_LOAD: begin
        if (w.load_slot < DEPTH) tx_bytes[w.load_slot] = w.load_value;
      end
      ACT_START: begin
        if (trk_phase != PH_IDLE || (wc == 0 && rc == 0)) begin
          r.rejected = 1'b1;
        end else begin
          trk_addr = w.target_address;
          wr_total = wc;
          rd_total = rc;
          wr_sent = '0;
          rd_got = '0;
          r.bus_address = trk_addr;
          if (wc == 0) begin
            r.read_flag = 1'b1;
            trk_phase = PH_RSTART;
          end else begin
            r.send_value = tx_bytes[0];
            wr_sent = 5'd1;
            r.command = (wc == 1) ? CMD_SINGLE_SEND : CMD_SEND_START;
            trk_phase = (wc == 1) ? PH_RSTART : PH_SEND;
          end
        end
      end
      ACT_POLL: begin
        if (trk_phase != PH_IDLE && !w.ctrl_busy) begin
          if (w.err_status != 0) begin
            r.done_res = 1'b1;
            r.fault_bits = w.err_status;
            trk_phase = PH_IDLE;
          end else begin
            case (trk_phase)
              PH_SEND: begin
                if (wr_total > wr_sent) begin
                  r.command = (wr_total - wr_sent == 1) ? CMD_SEND_FINISH : CMD_SEND_CONT;
                  r.send_value = tx_bytes[wr_sent[3:0]];
                  wr_sent = wr_sent + 1;
                  if (wr_sent == wr_total) begin
                    if (rd_total == 0) begin
                      r.done_res = 1'b1;
                      trk_phase = PH_IDLE;
                    end else begin
                      trk_phase = PH_RSTART;
                    end
                  end
                end
              end
              PH_RSTART: begin
                if (rd_total == 0) begin
                  r.done_res = 1'b1;
                  trk_phase = PH_IDLE;
                end else begin
                  r.command = (rd_total > 1) ? CMD_RECV_START : CMD_SINGLE_RECV;
                  r.bus_address = trk_addr;
                  r.read_flag = 1'b1;
                  trk_phase = PH_RECV;
                end
              end
              PH_RECV: begin
                if (rd_total > rd_got) begin
                  rd_got = rd_got + 1;
                  r.recv_valid = 1'b1;
                  r.recv_slot = 4'(rd_total - rd_got);
                  r.recv_value = w.received_value;
                  if (rd_got == rd_total) begin
                    r.done_res = 1'b1;
                    trk_phase = PH_IDLE;
                  end else begin
                    r.command = (rd_total - rd_got == 1) ? CMD_RECV_FINISH : CMD_RECV_CONT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t any_req();
    in_item_t w;
    w = in_item_t'({$urandom, $urandom});
    return w;
  endfunction

  function automatic in_item_t load_req(int slot, int value);
    in_item_t w;
    w = any_req();
    w.action = ACT_LOAD;
    w.load_slot = 4'(slot);
    w.load_value = 8'(value);
    return w;
  endfunction

  function automatic in_item_t start_req(int addr, int wc, int rc);
    in_item_t w;
    w = any_req();
    w.action = ACT_START;
    w.target_address = 7'(addr);
    w.write_count = 5'(wc);
    w.read_count = 5'(rc);
    return w;
  endfunction

  function automatic in_item_t poll_req(bit busy, int err, int rx);
    in_item_t w;
    w = any_req();
    w.action = ACT_POLL;
    w.ctrl_busy = busy;
    w.err_status = 4'(err);
    w.received_value = 8'(rx);
    return w;
  endfunction

  function automatic in_item_t odd_req();
    in_item_t w;
    w = any_req();
    w.action = ACT_UNUSED;
    return w;
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 4);
    if (r < 95) return $urandom_range(0, 16);
    return $urandom_range(17, 31);
  endfunction

  task automatic random_transaction();
    int wc, rc, swc, src, polls_left, r;
    wc = pick_count();
    rc = pick_count();
    host_requests.push_back(start_req($urandom_range(0, 127), wc, rc));
    swc = (wc > DEPTH) ? DEPTH : wc;
    src = (rc > DEPTH) ? DEPTH : rc;
    if (swc == 0 && src == 0) return;
    polls_left = ((swc > 1) ? swc - 1 : 0) + ((src > 0) ? src + 1 : ((swc == 1) ? 1 : 0));
    while (polls_left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        host_requests.push_back(poll_req(1'b1, $urandom_range(0, 15), $urandom_range(0, 255)));
      end else if (r < 23) begin
        host_requests.push_back(poll_req(1'b0, $urandom_range(1, 15), $urandom_range(0, 255)));
        return;
      end else if (r < 28) begin
        host_requests.push_back(load_req($urandom_range(0, 15), $urandom_range(0, 255)));
      end else if (r < 31) begin
        host_requests.push_back(start_req($urandom_range(0, 127), pick_count(), pick_count()));
      end else if (r < 32) begin
        host_requests.push_back(odd_req());
      end else begin
        host_requests.push_back(poll_req(1'b0, 0, $urandom_range(0, 255)));
        polls_left--;
      end
    end
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_wait > 0) begin
        in_wait--;
        in_ch.valid <= 1'b0;
      end else if (host_requests.size() > 0) begin
        in_ch.data <= host_requests.pop_front();
        in_ch.valid <= 1'b1;
        in_wait = draw_gap(in_steady);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result-side stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_taken) out_wait = draw_gap(out_steady);
      else if (out_wait > 0) out_wait--;
      out_ch.ready <= (out_wait == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (words_due.size() == 0) begin
          $error("result word with nothing outstanding");
          errors++;
        end else begin
          want = words_due.pop_front();
          check_field("command", want.command, out_ch.data.command);
          check_field("bus_address", want.bus_address, out_ch.data.bus_address);
          check_field("read_flag", want.read_flag, out_ch.data.read_flag);
          check_field("send_value", want.send_value, out_ch.data.send_value);
          check_field("recv_valid", want.recv_valid, out_ch.data.recv_valid);
          check_field("recv_slot", want.recv_slot, out_ch.data.recv_slot);
          check_field("recv_value", want.recv_value, out_ch.data.recv_value);
          check_field("done_res", want.done_res, out_ch.data.done_res);
          check_field("fault_bits", want.fault_bits, out_ch.data.fault_bits);
          check_field("rejected", want.rejected, out_ch.data.rejected);
          checked++;
          if (want.done_res && want.fault_bits == 0) finished++;
          if (want.fault_bits != 0) aborted++;
          if (want.rejected) refused++;
          if (want.recv_valid) recv_bytes++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        words_due.push_back(controller_word(in_ch.data));
        accepted++;
      end
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    in_wait = 0;
    out_wait = 0;
    trk_phase = PH_IDLE;
    trk_addr = '0;
    wr_total = '0;
    rd_total = '0;
    wr_sent = '0;
    rd_got = '0;

    // fill the whole transmit buffer so no unwritten byte is ever sent
    for (int i = 0; i < DEPTH; i++)
      host_requests.push_back(load_req(i, (i == 0) ? 8'hFF : (i == 15) ? 8'h00 : $urandom));

    // single-byte write without read
    host_requests.push_back(start_req(7'h7F, 1, 0));
    host_requests.push_back(poll_req(1'b0, 0, 0));
    // both counts zero
    host_requests.push_back(start_req(7'h11, 0, 0));
    // read-only, start while active, busy poll
    host_requests.push_back(start_req(7'h00, 0, 1));
    host_requests.push_back(start_req(7'h05, 3, 3));
    host_requests.push_back(poll_req(1'b1, 4'hF, 8'h00));
    host_requests.push_back(poll_req(1'b0, 0, 8'h00));
    host_requests.push_back(poll_req(1'b0, 0, 8'hFF));
    // saturated counts, load while active, abort on all error bits
    host_requests.push_back(start_req(7'h2A, 31, 31));
    host_requests.push_back(load_req(1, 8'h5A));
    host_requests.push_back(poll_req(1'b0, 0, 8'h00));
    host_requests.push_back(poll_req(1'b0, 4'hF, 8'h00));
    // idle poll, unused action
    host_requests.push_back(poll_req(1'b0, 0, 8'h00));
    host_requests.push_back(odd_req());
    // full write-then-read
    host_requests.push_back(start_req(7'h55, 2, 2));
    for (int i = 0; i < 4; i++)
      host_requests.push_back(poll_req(1'b0, 0, (i == 2) ? 8'h00 : 8'hA5));
    // multi-byte write without read
    host_requests.push_back(start_req(7'h33, 3, 0));
    host_requests.push_back(poll_req(1'b0, 0, 0));
    host_requests.push_back(poll_req(1'b0, 0, 0));

    r = host_requests.size();
    while (host_requests.size() - r < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: host_requests.push_back(load_req($urandom_range(0, 15), $urandom_range(0, 255)));
        1: host_requests.push_back(poll_req($urandom_range(0, 1), $urandom_range(0, 15),
                                            $urandom_range(0, 255)));
        2: host_requests.push_back(odd_req());
        default: random_transaction();
      endcase
    end
    total_items = host_requests.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted < total_items) @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words, checked %0d results in %0d cycles.", accepted, checked, cycles);
    $display("Transactions: %0d completed, %0d aborted, %0d starts refused, %0d bytes read.",
             finished, aborted, refused, recv_bytes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
